[hw/rtl/tme_pkg.sv]
// shared constants for the tape machine execute unit
package tme_pkg;

  localparam int TAPE_CELLS = 32768;
  localparam int HEAD_W     = $clog2(TAPE_CELLS);
  // head arithmetic width: covers the head, an 8-bit offset and the tape size itself
  localparam int MV_W       = ((HEAD_W > 8) ? HEAD_W : 8) + 1;

  localparam int S_DATA_W   = 40;
  localparam int M_DATA_W   = 16;

  localparam logic [3:0] OP_INC    = 4'd0;
  localparam logic [3:0] OP_DEC    = 4'd1;
  localparam logic [3:0] OP_ADD    = 4'd2;
  localparam logic [3:0] OP_LEFT   = 4'd3;
  localparam logic [3:0] OP_RIGHT  = 4'd4;
  localparam logic [3:0] OP_MOVE   = 4'd5;
  localparam logic [3:0] OP_OUT    = 4'd6;
  localparam logic [3:0] OP_IN     = 4'd7;
  localparam logic [3:0] OP_LSTART = 4'd8;
  localparam logic [3:0] OP_LEND   = 4'd9;
  localparam logic [3:0] OP_QUIT   = 4'd10;

  localparam logic [1:0] ST_RUN    = 2'd0;
  localparam logic [1:0] ST_QUIT   = 2'd1;
  localparam logic [1:0] ST_LEFT   = 2'd2;
  localparam logic [1:0] ST_RIGHT  = 2'd3;

endpackage

[hw/rtl/tape_machine_execute.sv]
// execute unit of the byte-tape machine: head tracking, tape cell update, result beat
//
// One decoded instruction per beat, one result beat per instruction. After reset the tape
// is cleared by a pass that writes one cell per cycle, once over every tape cell, during
// which s_tready stays low. After that an instruction is taken every cycle while the
// result side keeps up: the head move and the halt decision are made as the beat is
// accepted, the tape cell is read from the memory in that cycle, and it is modified and
// written back in the second stage once the output register can take the result, with
// the last write forwarded when the following instruction hits the same cell. A quit or
// a head move off either end of the tape halts the unit; every later instruction then
// changes nothing and reports the halt status until reset.
module tape_machine_execute (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // mode[3:0], operand[11:4], jump_target[27:12], in_byte[35:28], zero fill
  input  logic [tme_pkg::S_DATA_W-1:0] s_tdata,
  // in_eof[0]
  input  logic [0:0]                   s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // jump_taken[0], out_byte[8:1], run_status[10:9], zero fill
  output logic [tme_pkg::M_DATA_W-1:0] m_tdata,
  // out_valid[0]
  output logic [0:0]                   m_tuser
);

  localparam int HW = tme_pkg::HEAD_W;
  localparam int MW = tme_pkg::MV_W;
  localparam logic [MW-1:0] TAPE_END = MW'(tme_pkg::TAPE_CELLS);
  localparam logic [HW-1:0] LAST_CELL = HW'(tme_pkg::TAPE_CELLS - 1);

  // input fields
  logic [3:0] in_mode;
  logic [7:0] in_operand;
  logic [7:0] in_data;
  logic       in_eof;

  assign in_mode    = s_tdata[3:0];
  assign in_operand = s_tdata[11:4];
  assign in_data    = s_tdata[35:28];
  assign in_eof     = s_tuser[0];

  // control state
  logic          clearing;
  logic [HW-1:0] clr_cnt;
  logic [HW-1:0] head;
  logic [HW-1:0] head_next;
  logic [1:0]    halt;
  logic [1:0]    halt_next;

  // second stage
  logic          s1_valid;
  logic          s1_act;
  logic [3:0]    s1_mode;
  logic [7:0]    s1_operand;
  logic [7:0]    s1_data;
  logic          s1_eof;
  logic [HW-1:0] s1_addr;
  logic [1:0]    s1_status;

  // last tape write, for read-after-write on the same cell
  logic          fwd_valid;
  logic [HW-1:0] fwd_addr;
  logic [7:0]    fwd_data;

  // output register
  logic       out_jump;
  logic       out_flag;
  logic [7:0] out_byte;
  logic [1:0] out_status;

  logic       accept;
  logic       s1_adv;
  logic       running;
  logic [7:0] rd_data;
  logic [7:0] cur_cell;
  logic [7:0] cell_new;
  logic       cell_wr;
  logic       cell_we;
  logic       jump;
  logic       outv;
  logic [7:0] outb;

  logic [MW-1:0] head_w;
  logic [MW-1:0] head_inc;
  logic [MW-1:0] head_sum;
  logic [MW-1:0] back;
  logic [MW-1:0] head_diff;

  logic          ram_we;
  logic [HW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;

  assign s1_adv   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !clearing && (!s1_valid || s1_adv);
  assign accept   = s_tvalid && s_tready;
  assign running  = (halt == tme_pkg::ST_RUN);

  // head move and halt decision, made as the beat is taken
  assign head_w    = MW'(head);
  assign head_inc  = head_w + MW'(1);
  assign head_sum  = head_w + MW'(in_operand);
  assign back      = MW'(9'd256 - {1'b0, in_operand});
  assign head_diff = head_w - back;

  always_comb begin
    head_next = head;
    halt_next = halt;
    if (running) begin
      unique case (in_mode)
        tme_pkg::OP_LEFT: begin
          if (head == '0) halt_next = tme_pkg::ST_LEFT;
          else            head_next = head - HW'(1);
        end
        tme_pkg::OP_RIGHT: begin
          if (head_inc >= TAPE_END) halt_next = tme_pkg::ST_RIGHT;
          else                      head_next = head_inc[HW-1:0];
        end
        tme_pkg::OP_MOVE: begin
          if (in_operand[7]) begin
            if (back > head_w) halt_next = tme_pkg::ST_LEFT;
            else               head_next = head_diff[HW-1:0];
          end else begin
            if (head_sum >= TAPE_END) halt_next = tme_pkg::ST_RIGHT;
            else                      head_next = head_sum[HW-1:0];
          end
        end
        tme_pkg::OP_QUIT: halt_next = tme_pkg::ST_QUIT;
        default: ;
      endcase
    end
  end

  // cell read-modify-write in the second stage
  assign cur_cell = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : rd_data;

  always_comb begin
    cell_new = cur_cell;
    cell_wr  = 1'b0;
    jump     = 1'b0;
    outv     = 1'b0;
    outb     = 8'd0;
    if (s1_act) begin
      case (s1_mode)
        tme_pkg::OP_INC: begin
          cell_new = cur_cell + 8'd1;
          cell_wr  = 1'b1;
        end
        tme_pkg::OP_DEC: begin
          cell_new = cur_cell - 8'd1;
          cell_wr  = 1'b1;
        end
        tme_pkg::OP_ADD: begin
          cell_new = cur_cell + s1_operand;
          cell_wr  = 1'b1;
        end
        tme_pkg::OP_IN: begin
          cell_new = s1_eof ? 8'd0 : s1_data;
          cell_wr  = 1'b1;
        end
        tme_pkg::OP_OUT: begin
          outv = 1'b1;
          outb = cur_cell;
        end
        tme_pkg::OP_LSTART: jump = (cur_cell == 8'd0);
        tme_pkg::OP_LEND:   jump = (cur_cell != 8'd0);
        default: ;
      endcase
    end
  end

  assign cell_we = s1_adv && cell_wr;

  assign ram_we    = clearing || cell_we;
  assign ram_waddr = clearing ? clr_cnt : s1_addr;
  assign ram_wdata = clearing ? 8'd0 : cell_new;

  tme_ram #(
    .WIDTH (8),
    .DEPTH (tme_pkg::TAPE_CELLS)
  ) u_tape (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (head),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_cnt   <= '0;
      head      <= '0;
      halt      <= tme_pkg::ST_RUN;
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + HW'(1);
        if (clr_cnt == LAST_CELL) clearing <= 1'b0;
      end
      if (accept) begin
        head     <= head_next;
        halt     <= halt_next;
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (cell_we) begin
        fwd_valid <= 1'b1;
      end
      if (s1_adv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_act     <= running;
      s1_mode    <= in_mode;
      s1_operand <= in_operand;
      s1_data    <= in_data;
      s1_eof     <= in_eof;
      s1_addr    <= head;
      s1_status  <= halt_next;
    end
    if (cell_we) begin
      fwd_addr <= s1_addr;
      fwd_data <= cell_new;
    end
    if (s1_adv) begin
      out_jump   <= jump;
      out_flag   <= outv;
      out_byte   <= outb;
      out_status <= s1_status;
    end
  end

  assign m_tdata = {5'd0, out_status, out_byte, out_jump};
  assign m_tuser = out_flag;

  // a halt is final until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halt != tme_pkg::ST_RUN |=> halt == $past(halt))
    else $error("halt code changed after halting");

  // nothing in flight while the tape is being cleared
  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s1_valid && !m_tvalid && !cell_we)
    else $error("instruction in flight during tape clear");

  // the head never leaves the tape
  a_head_range: assert property (@(posedge clk) disable iff (rst)
    MW'(head) < TAPE_END)
    else $error("head index beyond tape");

  // an output byte only comes from a running machine
  a_out_running: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[10:9] == tme_pkg::ST_RUN)
    else $error("output byte with halted status");

endmodule

[hw/rtl/tme_ram.sv]
// generic single-port-write ram with registered read
module tme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[tb/sv/tb_tape_machine_execute.sv]
// testbench for the tape machine execute unit: directed and random beats against a predictor
module tb_tape_machine_execute;

  localparam logic [3:0] OP_UNDEF_LO = 4'd11;
  localparam logic [3:0] OP_UNDEF_HI = 4'd15;
  localparam int IDLE_LIMIT  = 150000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [3:0]  mode;
    logic [7:0]  operand;
    logic [15:0] jump_target;
    logic [7:0]  in_byte;
    logic        in_eof;
  } instr_t;

  typedef struct {
    logic       jump_taken;
    logic       out_valid;
    logic [7:0] out_byte;
    logic [1:0] run_status;
  } result_t;

  typedef enum {RX_FREE, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_pat_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [tme_pkg::S_DATA_W-1:0] s_tdata = '0;
  logic [0:0]                   s_tuser = '0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [tme_pkg::M_DATA_W-1:0] m_tdata;
  logic [0:0]                   m_tuser;

  tape_machine_execute dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // predictor state
  logic [7:0] tape_img [tme_pkg::TAPE_CELLS];
  int         head_pos;
  logic [1:0] halt_st;
  result_t    pending_results[$];

  int      fails = 0;
  int      burst_left = 0;
  bit      gaps_on = 1'b1;
  int      hold_req = 0;
  int      hold_ack = 0;
  int      hold_left = 0;
  rx_pat_t rx_pat = RX_FREE;
  int      rx_cycles = 0;
  int      idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic result_t execute_instr(instr_t it);
    result_t r;
    int h;
    int back;
    r = '{default: '0};
    h = head_pos;
    if (halt_st == tme_pkg::ST_RUN) begin
      case (it.mode)
        tme_pkg::OP_INC:    tape_img[h] = tape_img[h] + 8'd1;
        tme_pkg::OP_DEC:    tape_img[h] = tape_img[h] - 8'd1;
        tme_pkg::OP_ADD:    tape_img[h] = tape_img[h] + it.operand;
        tme_pkg::OP_LEFT: begin
          if (h == 0) halt_st = tme_pkg::ST_LEFT;
          else head_pos = h - 1;
        end
        tme_pkg::OP_RIGHT: begin
          if (h + 1 >= tme_pkg::TAPE_CELLS) halt_st = tme_pkg::ST_RIGHT;
          else head_pos = h + 1;
        end
        tme_pkg::OP_MOVE: begin
          if (it.operand[7]) begin
            back = 256 - int'(it.operand);
            if (back > h) halt_st = tme_pkg::ST_LEFT;
            else head_pos = h - back;
          end else begin
            if (h + int'(it.operand) >= tme_pkg::TAPE_CELLS) halt_st = tme_pkg::ST_RIGHT;
            else head_pos = h + int'(it.operand);
          end
        end
        tme_pkg::OP_OUT: begin
          r.out_valid = 1'b1;
          r.out_byte  = tape_img[h];
        end
        tme_pkg::OP_IN:     tape_img[h] = it.in_eof ? 8'd0 : it.in_byte;
        tme_pkg::OP_LSTART: r.jump_taken = (tape_img[h] == 8'd0);
        tme_pkg::OP_LEND:   r.jump_taken = (tape_img[h] != 8'd0);
        tme_pkg::OP_QUIT:   halt_st = tme_pkg::ST_QUIT;
        default: ;
      endcase
    end
    r.run_status = halt_st;
    return r;
  endfunction

  function automatic instr_t mk_instr(logic [3:0] mode, logic [7:0] operand);
    instr_t it;
    it.mode        = mode;
    it.operand     = operand;
    it.jump_target = 16'($urandom_range(0, 65535));
    it.in_byte     = 8'($urandom_range(0, 255));
    it.in_eof      = ($urandom_range(0, 4) == 0);
    return it;
  endfunction

  // random instruction that keeps the head on the tape
  function automatic instr_t rand_instr();
    instr_t it;
    int pick;
    int tgt;
    logic [3:0] mode;
    do begin
      pick = $urandom_range(0, 99);
      if (pick < 12)      mode = tme_pkg::OP_INC;
      else if (pick < 20) mode = tme_pkg::OP_DEC;
      else if (pick < 32) mode = tme_pkg::OP_ADD;
      else if (pick < 42) mode = tme_pkg::OP_LEFT;
      else if (pick < 52) mode = tme_pkg::OP_RIGHT;
      else if (pick < 62) mode = tme_pkg::OP_MOVE;
      else if (pick < 72) mode = tme_pkg::OP_OUT;
      else if (pick < 82) mode = tme_pkg::OP_IN;
      else if (pick < 89) mode = tme_pkg::OP_LSTART;
      else if (pick < 96) mode = tme_pkg::OP_LEND;
      else                mode = 4'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
      it = mk_instr(mode, 8'($urandom_range(0, 255)));
      tgt = head_pos;
      if (mode == tme_pkg::OP_LEFT) tgt = head_pos - 1;
      else if (mode == tme_pkg::OP_RIGHT) tgt = head_pos + 1;
      else if (mode == tme_pkg::OP_MOVE) tgt = head_pos + int'($signed(it.operand));
    end while (tgt < 0 || tgt >= tme_pkg::TAPE_CELLS);
    return it;
  endfunction

  task automatic send_instr(input instr_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = {4'b0, it.in_byte, it.jump_target, it.operand, it.mode};
    s_tuser  = it.in_eof;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(execute_instr(it));
  endtask

  task automatic wait_drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic walk_head(int target);
    int d;
    while (head_pos != target) begin
      d = target - head_pos;
      if (d > 127) d = 127;
      if (d < -128) d = -128;
      send_instr(mk_instr(tme_pkg::OP_MOVE, d[7:0]));
    end
  endtask

  task automatic test_cell_ops();
    instr_t it;
    gaps_on = 1'b0;
    send_instr(mk_instr(tme_pkg::OP_OUT, 8'd0));
    it = mk_instr(tme_pkg::OP_LSTART, 8'd0);
    it.jump_target = 16'hFFFF;
    send_instr(it);
    it = mk_instr(tme_pkg::OP_LEND, 8'hFF);
    it.jump_target = 16'h0000;
    send_instr(it);
    send_instr(mk_instr(tme_pkg::OP_INC, 8'd0));
    send_instr(mk_instr(tme_pkg::OP_OUT, 8'd0));
    send_instr(mk_instr(tme_pkg::OP_DEC, 8'd0));
    // wraps below zero
    send_instr(mk_instr(tme_pkg::OP_DEC, 8'd0));
    send_instr(mk_instr(tme_pkg::OP_OUT, 8'd0));
    send_instr(mk_instr(tme_pkg::OP_LEND, 8'd0));
    send_instr(mk_instr(tme_pkg::OP_LSTART, 8'd0));
    send_instr(mk_instr(tme_pkg::OP_ADD, 8'hFF));
    send_instr(mk_instr(tme_pkg::OP_ADD, 8'h00));
    send_instr(mk_instr(tme_pkg::OP_ADD, 8'h80));
    send_instr(mk_instr(tme_pkg::OP_OUT, 8'd0));
    it = mk_instr(tme_pkg::OP_IN, 8'd0);
    it.in_byte = 8'hA5;
    it.in_eof  = 1'b0;
    send_instr(it);
    send_instr(mk_instr(tme_pkg::OP_OUT, 8'd0));
    // end of input stores zero whatever the byte
    it = mk_instr(tme_pkg::OP_IN, 8'd0);
    it.in_byte = 8'hFF;
    it.in_eof  = 1'b1;
    send_instr(it);
    send_instr(mk_instr(tme_pkg::OP_OUT, 8'd0));
    it = mk_instr(OP_UNDEF_LO, 8'hFF);
    it.in_byte = 8'hFF;
    send_instr(it);
    send_instr(mk_instr(OP_UNDEF_HI, 8'h5A));
    send_instr(mk_instr(tme_pkg::OP_RIGHT, 8'd0));
    send_instr(mk_instr(tme_pkg::OP_INC, 8'd0));
    send_instr(mk_instr(tme_pkg::OP_LEFT, 8'd0));
    send_instr(mk_instr(tme_pkg::OP_MOVE, 8'h7F));
    send_instr(mk_instr(tme_pkg::OP_MOVE, 8'h7F));
    send_instr(mk_instr(tme_pkg::OP_MOVE, 8'h80));
    send_instr(mk_instr(tme_pkg::OP_MOVE, 8'h00));
    send_instr(mk_instr(tme_pkg::OP_OUT, 8'd0));
    wait_drain();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_stream(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      // sender pauses until every result is back
      if (i % 150 == 149) wait_drain();
      send_instr(rand_instr());
    end
    wait_drain();
    gaps_on = 1'b1;
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_req++;
    repeat (40) send_instr(rand_instr());
    wait_drain();
    gaps_on = 1'b1;
  endtask

  task automatic test_halt();
    int kind;
    int back;
    int rem;
    kind = $urandom_range(0, 4);
    case (kind)
      0: send_instr(mk_instr(tme_pkg::OP_QUIT, 8'($urandom_range(0, 255))));
      1: begin
        walk_head(0);
        send_instr(mk_instr(tme_pkg::OP_LEFT, 8'd0));
      end
      2: begin
        walk_head($urandom_range(0, 100));
        back = $urandom_range(head_pos + 1, 128);
        send_instr(mk_instr(tme_pkg::OP_MOVE, 8'(256 - back)));
      end
      3: begin
        walk_head(tme_pkg::TAPE_CELLS - 1);
        send_instr(mk_instr(tme_pkg::OP_INC, 8'd0));
        send_instr(mk_instr(tme_pkg::OP_OUT, 8'd0));
        send_instr(mk_instr(tme_pkg::OP_RIGHT, 8'd0));
      end
      default: begin
        walk_head(tme_pkg::TAPE_CELLS - 1 - $urandom_range(0, 126));
        rem = tme_pkg::TAPE_CELLS - 1 - head_pos;
        send_instr(mk_instr(tme_pkg::OP_MOVE, 8'($urandom_range(rem + 1, 127))));
      end
    endcase
    // halted: nothing may change any more
    repeat (40)
      send_instr(mk_instr(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255))));
    wait_drain();
  endtask

  // receiver stall pattern, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_ack != hold_req) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (rx_cycles == 0) begin
      rx_pat    = rx_pat_t'($urandom_range(0, 3));
      rx_cycles = $urandom_range(20, 200);
    end else begin
      rx_cycles--;
    end
    if (hold_left > 0) begin
      m_tready = 1'b0;
      hold_left--;
    end else begin
      case (rx_pat)
        RX_FREE:   m_tready = 1'b1;
        RX_HALF:   m_tready = 1'($urandom_range(0, 1));
        RX_SPARSE: m_tready = ($urandom_range(0, 3) == 0);
        default:   m_tready = (rx_cycles % 4 != 0);
      endcase
    end
  end

  always @(posedge clk) begin : check_result
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        fails++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[0] !== want.jump_taken) begin
          $error("jump_taken: expected %0d, got %0d", want.jump_taken, m_tdata[0]);
          fails++;
        end
        if (m_tuser[0] !== want.out_valid) begin
          $error("out_valid: expected %0d, got %0d", want.out_valid, m_tuser[0]);
          fails++;
        end
        if (m_tdata[8:1] !== want.out_byte) begin
          $error("out_byte: expected %0d, got %0d", want.out_byte, m_tdata[8:1]);
          fails++;
        end
        if (m_tdata[10:9] !== want.run_status) begin
          $error("run_status: expected %0d, got %0d", want.run_status, m_tdata[10:9]);
          fails++;
        end
      end
    end
  end

  // idle watchdog, with a limit that covers the tape clearing pass after reset
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < tme_pkg::TAPE_CELLS; i++) tape_img[i] = 8'd0;
    head_pos = 0;
    halt_st  = tme_pkg::ST_RUN;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_cell_ops();
    test_random_stream(600);
    test_backpressure();
    test_random_stream(100);
    test_halt();
    repeat (10) @(posedge clk);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
